// File: rtl/tsm_pkg.sv
package tsm_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CFG_AW = 4;

  localparam logic [7:0] FULL_SLOT = 8'd255;

  localparam logic [1:0] FUNC_FRAME = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_PRUNE = 2'd2;

  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_ASSIGNED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [1:0] REG_COORD   = 2'd0;
  localparam logic [1:0] REG_OWN_ID  = 2'd1;
  localparam logic [1:0] REG_MAX_AGE = 2'd2;

  typedef enum logic [1:0] {
    OP_SCAN,
    OP_CLAIM,
    OP_PRUNE
  } tok_op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] sender_id;
    logic       is_join;
    logic [7:0] joining_node_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  ack_slot;
    logic [31:0] frame_count;
  } out_item_t;

  typedef struct packed {
    logic             vld;
    tok_op_t          op;
    logic [7:0]       sender;
    logic [7:0]       joiner;
    logic             do_join;
    logic [31:0]      val;
    logic             sender_done;
    logic             join_hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } tok_t;

endpackage

// File: rtl/tsm_cell.sv
module tsm_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [tsm_pkg::IDX_W-1:0] cell_idx,
  input  logic [7:0]              head_id,
  input  tsm_pkg::tok_t           tok_i,
  output tsm_pkg::tok_t           tok_o
);
  import tsm_pkg::*;

  logic [7:0]  id_r, id_nxt;
  logic        active_r, active_nxt;
  logic [31:0] seen_r, seen_nxt;
  tok_t        tok_r, tok_nxt;
  logic        is_head;
  logic [7:0]  id_eff;

  assign is_head = (cell_idx == '0);
  assign id_eff  = is_head ? head_id : id_r;

  always_comb begin
    id_nxt     = id_r;
    active_nxt = active_r;
    seen_nxt   = seen_r;
    tok_nxt    = tok_i;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_SCAN: begin
          if (!tok_i.sender_done && id_eff == tok_i.sender) begin
            seen_nxt            = tok_i.val;
            tok_nxt.sender_done = 1'b1;
          end
          if (tok_i.do_join && !is_head) begin
            if (!tok_i.join_hit && id_r == tok_i.joiner) begin
              active_nxt       = 1'b1;
              seen_nxt         = tok_i.val;
              tok_nxt.join_hit = 1'b1;
              tok_nxt.hit_idx  = cell_idx;
            end
            if (!active_r && !tok_i.free_found) begin
              tok_nxt.free_found = 1'b1;
              tok_nxt.free_idx   = cell_idx;
            end
          end
        end
        OP_CLAIM: begin
          if (tok_i.free_found && !is_head && tok_i.free_idx == cell_idx) begin
            id_nxt     = tok_i.joiner;
            active_nxt = 1'b1;
            seen_nxt   = tok_i.val;
          end
        end
        OP_PRUNE: begin
          if (!is_head && active_r && seen_r < tok_i.val) begin
            active_nxt = 1'b0;
            id_nxt     = 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r     <= '0;
      active_r <= 1'b0;
      seen_r   <= '0;
      tok_r    <= '0;
    end else begin
      id_r     <= id_nxt;
      active_r <= active_nxt;
      seen_r   <= seen_nxt;
      tok_r    <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: rtl/tdma_slot_table_manager_core.sv
// tdma slot table manager, coordinator side
// input channel (in_valid / in_stall / in_data) takes one item at a time:
// a received frame, a heartbeat tick or a prune request. every item gives
// exactly one result on the output channel (out_valid / out_stall / out_data)
// carrying the join status, the acknowledged slot and the frame counter.
// the table is a chain of SLOTS cells; a token walks the chain one cell per
// cycle. a tick or an unused code goes straight to the result; a received
// frame or a prune sends one token down the chain, and so does a join that
// finds an existing entry or a full table; a join into a free entry needs a
// second walk that claims it.
// in_stall is high while an item is in progress; the next item can be taken
// as soon as its result sits in the output register, even if not yet taken.
// when out_stall is high the result holds and the block finishes no further
// item until it is taken.
// reset clears the table, the frame counter and the apb registers; the block
// takes items on the first cycle after reset. the user must write registers
// through the apb port only while idle; the block does not enforce it.
module tdma_slot_table_manager_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tsm_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tsm_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [tsm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import tsm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  state_t      state_r, state_nxt;
  logic        coord_r, coord_nxt;
  logic [7:0]  own_id_r, own_id_nxt;
  logic [31:0] max_age_r, max_age_nxt;
  logic [31:0] frame_cnt_r, frame_cnt_nxt;
  tok_t        launch_r, launch_nxt;
  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  tok_t        chain_w [SLOTS+1];
  tok_t        tail;
  logic [7:0]  head_id;
  logic        in_xfer, cfg_wr, out_free;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign head_id    = coord_r ? own_id_r : 8'd0;
  assign tail       = chain_w[SLOTS];
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    unique case (cfg_idx)
      REG_COORD:   cfg_prdata = {31'd0, coord_r};
      REG_OWN_ID:  cfg_prdata = {24'd0, own_id_r};
      REG_MAX_AGE: cfg_prdata = max_age_r;
      default:     cfg_prdata = 32'd0;
    endcase
  end

  assign chain_w[0] = launch_r;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .head_id  (head_id),
      .tok_i    (chain_w[g]),
      .tok_o    (chain_w[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    coord_nxt     = coord_r;
    own_id_nxt    = own_id_r;
    max_age_nxt   = max_age_r;
    frame_cnt_nxt = frame_cnt_r;
    launch_nxt    = '0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COORD:   coord_nxt   = cfg_pwdata[0];
        REG_OWN_ID:  own_id_nxt  = cfg_pwdata[7:0];
        REG_MAX_AGE: max_age_nxt = cfg_pwdata;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          res_nxt = '0;
          launch_nxt.sender = in_data.sender_id;
          launch_nxt.joiner = in_data.joining_node_id;
          unique case (in_data.func)
            FUNC_FRAME: begin
              launch_nxt.vld     = 1'b1;
              launch_nxt.op      = OP_SCAN;
              launch_nxt.do_join = coord_r && in_data.is_join;
              launch_nxt.val     = frame_cnt_r;
              state_nxt          = ST_WAIT;
            end
            FUNC_TICK: begin
              frame_cnt_nxt = frame_cnt_r + 32'd1;
              state_nxt     = ST_EMIT;
            end
            FUNC_PRUNE: begin
              launch_nxt.vld = 1'b1;
              launch_nxt.op  = OP_PRUNE;
              launch_nxt.val = frame_cnt_r - max_age_r;
              state_nxt      = ST_WAIT;
            end
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_WAIT: begin
        if (tail.vld) begin
          state_nxt = ST_EMIT;
          if (tail.op == OP_SCAN && tail.do_join) begin
            if (tail.join_hit) begin
              res_nxt.status   = STATUS_ASSIGNED;
              res_nxt.ack_slot = 8'(tail.hit_idx);
            end else if (tail.free_found) begin
              res_nxt.status   = STATUS_ASSIGNED;
              res_nxt.ack_slot = 8'(tail.free_idx);
              launch_nxt       = tail;
              launch_nxt.op    = OP_CLAIM;
              state_nxt        = ST_WAIT;
            end else begin
              res_nxt.status   = STATUS_FULL;
              res_nxt.ack_slot = FULL_SLOT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = res_r;
          out_data_nxt.frame_count = frame_cnt_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      coord_r     <= 1'b0;
      own_id_r    <= '0;
      max_age_r   <= '0;
      frame_cnt_r <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coord_r     <= coord_nxt;
      own_id_r    <= own_id_nxt;
      max_age_r   <= max_age_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_tail_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> state_r == ST_WAIT)
    else $error("token left the chain outside of a wait");

  a_single_launch: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r.vld |=> !launch_r.vld)
    else $error("two tokens launched back to back");

  a_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("block not busy after an input transfer");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == STATUS_FULL |-> out_data_r.ack_slot == FULL_SLOT)
    else $error("refused join without the full slot code");

  a_none_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == STATUS_NONE |-> out_data_r.ack_slot == 8'd0)
    else $error("slot reported without a join");

endmodule

// File: dv/tdma_slot_table_manager_core_test.sv
`timescale 1ns / 1ps

module tdma_slot_table_manager_core_test;
  import tsm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RAND_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // testbench copy of the table and registers
  logic [7:0] node_id [SLOTS];
  logic node_active [SLOTS];
  logic [31:0] node_stamp [SLOTS];
  logic [31:0] frame_ctr;
  logic coord_mode;
  logic [7:0] own_id;
  logic [31:0] max_age;

  in_item_t rx_items[$];
  out_item_t pending_acks[$];
  logic in_fire = 1'b0;
  bit in_throttle = 1'b0;
  bit out_throttle = 1'b0;
  int in_gap = 0;
  int out_hold = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int assigned_count = 0;
  int refused_count = 0;
  int prune_count = 0;
  int setting_count = 0;

  tdma_slot_table_manager_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t predict_ack(input in_item_t it);
    out_item_t r;
    logic [31:0] cutoff;
    int hit;
    int slot;
    r = '0;
    node_id[0] = coord_mode ? own_id : 8'd0;
    node_active[0] = coord_mode;
    case (it.func)
      FUNC_FRAME: begin
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && node_id[i] == it.sender_id) hit = i;
        if (hit >= 0) node_stamp[hit] = frame_ctr;
        if (coord_mode && it.is_join) begin
          slot = FULL_SLOT;
          // old entry first, even if inactive
          for (int i = 1; i < SLOTS; i++)
            if (slot == FULL_SLOT && node_id[i] == it.joining_node_id) slot = i;
          for (int i = 1; i < SLOTS; i++)
            if (slot == FULL_SLOT && !node_active[i]) slot = i;
          if (slot != FULL_SLOT) begin
            node_id[slot] = it.joining_node_id;
            node_active[slot] = 1'b1;
            node_stamp[slot] = frame_ctr;
            r.status = STATUS_ASSIGNED;
          end else begin
            r.status = STATUS_FULL;
          end
          r.ack_slot = slot[7:0];
        end
      end
      FUNC_TICK: frame_ctr = frame_ctr + 32'd1;
      FUNC_PRUNE: begin
        cutoff = frame_ctr - max_age;
        for (int i = 1; i < SLOTS; i++)
          if (node_active[i] && node_stamp[i] < cutoff) begin
            node_active[i] = 1'b0;
            node_id[i] = 8'd0;
          end
      end
      default: ;
    endcase
    r.frame_count = frame_ctr;
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) it.func = FUNC_FRAME;
    else if (pick < 80) it.func = FUNC_TICK;
    else if (pick < 95) it.func = FUNC_PRUNE;
    else it.func = FUNC_UNUSED;
    // a small id pool keeps rejoins, full tables and stamp hits frequent
    it.sender_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 23));
    it.is_join = 1'($urandom_range(0, 1));
    it.joining_node_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 23));
    return it;
  endfunction

  task automatic push_item(input logic [1:0] func, input logic [7:0] sender,
                           input logic join_req, input logic [7:0] joiner);
    in_item_t it;
    it.func = func;
    it.sender_id = sender;
    it.is_join = join_req;
    it.joining_node_id = joiner;
    rx_items.push_back(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_COORD: coord_mode = val[0];
      REG_OWN_ID: own_id = val[7:0];
      REG_MAX_AGE: max_age = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic coord, input logic [7:0] id, input logic [31:0] age);
    write_reg(REG_COORD, {31'd0, coord});
    write_reg(REG_OWN_ID, {24'd0, id});
    write_reg(REG_MAX_AGE, age);
    setting_count++;
  endtask

  task automatic drain();
    wait (rx_items.size() == 0 && pending_acks.size() == 0 && !in_valid);
    repeat (4) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold until transfer
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (rx_items.size() != 0 && in_throttle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_gap = $urandom_range(0, 6);
    end else if (rx_items.size() != 0) begin
      in_data <= rx_items.pop_front();
      in_valid <= 1'b1;
      sent_count++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result stall bursts
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else if (out_throttle && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      out_hold = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (pending_acks.size() == 0) begin
          $error("result transfer with nothing expected: %p", out_data);
          fail_count++;
        end else begin
          want = pending_acks.pop_front();
          checked_count++;
          if (want.status == STATUS_ASSIGNED) assigned_count++;
          if (want.status == STATUS_FULL) refused_count++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.ack_slot !== want.ack_slot) begin
            $error("ack_slot: expected %0d, got %0d", want.ack_slot, out_data.ack_slot);
            fail_count++;
          end
          if (out_data.frame_count !== want.frame_count) begin
            $error("frame_count: expected %0d, got %0d", want.frame_count,
                   out_data.frame_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.func == FUNC_PRUNE) prune_count++;
        pending_acks.push_back(predict_ack(in_data));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] age;
    logic [7:0] id;
    for (int i = 0; i < SLOTS; i++) begin
      node_id[i] = 8'd0;
      node_active[i] = 1'b0;
      node_stamp[i] = 32'd0;
    end
    frame_ctr = 32'd0;
    coord_mode = 1'b0;
    own_id = 8'd0;
    max_age = 32'd0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: not coordinator, joins only stamp
    push_item(FUNC_FRAME, 8'hFF, 1'b1, 8'hFF);
    push_item(FUNC_FRAME, 8'h00, 1'b1, 8'h00);
    push_item(FUNC_UNUSED, 8'hFF, 1'b1, 8'hFF);
    push_item(FUNC_TICK, 8'h00, 1'b0, 8'h00);
    push_item(FUNC_PRUNE, 8'h00, 1'b0, 8'h00);
    drain();

    // fill the table, overflow it, rejoin, then age everything out
    apply_setting(1'b1, 8'hFF, 32'd0);
    for (int n = 1; n < SLOTS; n++) push_item(FUNC_FRAME, n[7:0], 1'b1, n[7:0]);
    push_item(FUNC_FRAME, 8'd200, 1'b1, 8'd200);
    push_item(FUNC_FRAME, 8'd7, 1'b1, 8'd7);
    push_item(FUNC_FRAME, 8'hFF, 1'b0, 8'h00);
    push_item(FUNC_TICK, 8'h00, 1'b0, 8'h00);
    push_item(FUNC_PRUNE, 8'h00, 1'b0, 8'h00);
    push_item(FUNC_FRAME, 8'h00, 1'b0, 8'h00);
    push_item(FUNC_FRAME, 8'h00, 1'b1, 8'h00);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      in_throttle = (p < RAND_PHASES - 3) && ($urandom_range(0, 3) != 0);
      out_throttle = (p < RAND_PHASES - 3) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: id = 8'h00;
        1: id = 8'hFF;
        default: id = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
        0: age = 32'd0;
        1: age = 32'hFFFF_FFFF;
        2: age = $urandom_range(1, 4);
        3: age = $urandom_range(5, 40);
        4: age = $urandom;
        default: age = 32'h8000_0000;
      endcase
      apply_setting((p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0), id, age);
      repeat (ITEMS_PER_PHASE) rx_items.push_back(random_item());
      drain();
    end

    repeat (40) @(posedge clk);
    $display("%0d items sent, %0d results checked over %0d register settings",
             sent_count, checked_count, setting_count);
    $display("%0d slots assigned, %0d joins refused, %0d prune passes",
             assigned_count, refused_count, prune_count);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tsm_pkg.sv
rtl/tsm_cell.sv
rtl/tdma_slot_table_manager_core.sv
dv/tdma_slot_table_manager_core_test.sv
